[rtl/core/vcoc_pkg.sv]
// ============================================================================
// vcoc_pkg
// Shared types, codes and constants of the voxel column occupancy classifier.
// ============================================================================
`default_nettype none

package vcoc_pkg;

    // Default geometry of the voxel grid.
    localparam int unsigned GRID_X_DEF = 128;
    localparam int unsigned GRID_Y_DEF = 128;
    localparam int unsigned LAYERS_DEF = 32;

    // Fixed port field widths.
    localparam int unsigned CELL_W      = 7;
    localparam int unsigned LAYER_Z_W   = 5;
    localparam int unsigned CLASS_W     = 2;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned FLOOR_W     = 5;
    localparam int unsigned LCOUNT_W    = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 6;

    // Request types.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Classification codes.
    localparam logic [CLASS_W-1:0] CLASS_OCCUPIED = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_FREE     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN  = 2'd2;

    // Classification modes.
    localparam logic [MODE_W-1:0] MODE_ALL         = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BELOW       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BELOW_FLOOR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_INDEX = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_COUNT = 2'd2;

    // Configuration reset values.
    localparam logic [MODE_W-1:0]   CLASS_MODE_RST  = 2'd0;
    localparam logic [FLOOR_W-1:0]  FLOOR_INDEX_RST = 5'd1;
    localparam logic [LCOUNT_W-1:0] LAYER_COUNT_RST = 6'd32;

    // Width of a per-byte population count (0..8).
    localparam int unsigned GRP_CNT_W = 4;

    // Saturation limit of the reported band count.
    localparam int unsigned COUNT_MAX = 63;

    // Ratio thresholds as exact integer cross-multiplications.
    localparam int unsigned RATIO_HI_MUL   = 10;   // c / n >= 0.1
    localparam int unsigned RATIO_BAND_MUL = 4;    // c / n >= 0.25
    localparam int unsigned RATIO_LO_CMUL  = 1000; // c / n <= 0.036
    localparam int unsigned RATIO_LO_NMUL  = 36;

    // Control word of the second pipeline stage.
    typedef struct packed {
        logic               valid;
        logic               below;
        logic               floor_seen;
        logic [MODE_W-1:0]  mode;
    } stage_ctl_t;

endpackage

`default_nettype wire

[rtl/core/vcoc_column_store.sv]
// ============================================================================
// vcoc_column_store
// Column word memory with a clearing sweep after reset and write forwarding.
// ============================================================================
`default_nettype none

module vcoc_column_store #(
    parameter int unsigned DEPTH  = vcoc_pkg::GRID_X_DEF * vcoc_pkg::GRID_Y_DEF,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int unsigned COL_W  = vcoc_pkg::LAYERS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [COL_W-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [COL_W-1:0]  wr_data,
    output logic                   clearing
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [COL_W-1:0]  mem [DEPTH];
    logic [COL_W-1:0]  rd_q_reg;
    logic              byp_hit_reg;
    logic [COL_W-1:0]  byp_data_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic [ADDR_W-1:0] clear_cnt_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [COL_W-1:0]  mem_wdata;

    // The sweep owns the write port until every entry holds zero.
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
        clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clear_cnt_reg <= clear_cnt_next;
                if (clear_cnt_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            // A read that meets a write to the same entry sees the new word.
            byp_hit_reg <= rd_en && wr_en && !clearing_reg && (rd_addr == wr_addr);
        end
    end

    assign rd_data  = byp_hit_reg ? byp_data_reg : rd_q_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

[rtl/core/voxel_column_occupancy_classifier.sv]
// ============================================================================
// voxel_column_occupancy_classifier
// Voxel occupancy store with per-column occupied / free / unknown queries.
// ============================================================================
// The block takes one request per clock cycle whenever busy is low: a load
// sets or clears one voxel, a query classifies one grid column. A query
// result appears on cell_class and band_count for exactly one cycle, marked
// by done, once the query has passed the stage 1, stage 2, stage 3 and
// output registers; loads give no result. The receiver cannot stall the
// block, so the result must be taken in that cycle. After reset, busy stays
// high while a sweep clears all GRID_X * GRID_Y words of the column memory
// one word per cycle; configuration writes are taken during that time too.
// Once the sweep is done, the sustained rate is one request per cycle, set by
// the single read and single write port of the column memory: each request
// reads one column word, and a load writes the modified word back in the
// cycle after the read, with a bypass that hands that word to a read of the
// same column in the same cycle.
// ============================================================================
`default_nettype none

module voxel_column_occupancy_classifier #(
    parameter int unsigned GRID_X = vcoc_pkg::GRID_X_DEF,
    parameter int unsigned GRID_Y = vcoc_pkg::GRID_Y_DEF,
    parameter int unsigned LAYERS = vcoc_pkg::LAYERS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Request channel.
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                req_type,
    input  wire logic [vcoc_pkg::CELL_W-1:0]         cell_x,
    input  wire logic [vcoc_pkg::CELL_W-1:0]         cell_y,
    input  wire logic [vcoc_pkg::LAYER_Z_W-1:0]      layer_z,
    input  wire logic                                voxel_filled,
    // Result channel.
    output logic                                     done,
    output logic      [vcoc_pkg::CLASS_W-1:0]        cell_class,
    output logic      [vcoc_pkg::COUNT_W-1:0]        band_count,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [vcoc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [vcoc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned DEPTH  = GRID_X * GRID_Y;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Width that holds any layer count from 0 to LAYERS.
    localparam int unsigned L_W    = $clog2(LAYERS + 1);
    // The column is counted in groups of eight bits.
    localparam int unsigned NGRP   = (LAYERS + 7) / 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [vcoc_pkg::MODE_W-1:0]   class_mode_reg;
    logic [vcoc_pkg::FLOOR_W-1:0]  floor_index_reg;
    logic [vcoc_pkg::LCOUNT_W-1:0] layer_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_mode_reg  <= vcoc_pkg::CLASS_MODE_RST;
            floor_index_reg <= vcoc_pkg::FLOOR_INDEX_RST;
            layer_count_reg <= vcoc_pkg::LAYER_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vcoc_pkg::CFG_CLASS_MODE:
                begin
                    class_mode_reg <= cfg_data[vcoc_pkg::MODE_W-1:0];
                end
                vcoc_pkg::CFG_FLOOR_INDEX:
                begin
                    floor_index_reg <= cfg_data[vcoc_pkg::FLOOR_W-1:0];
                end
                vcoc_pkg::CFG_LAYER_COUNT:
                begin
                    layer_count_reg <= cfg_data[vcoc_pkg::LCOUNT_W-1:0];
                end
                default:
                begin
                    // Writes to an unassigned index are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request transfer and address formation
    // ------------------------------------------------------------------
    logic              clearing;
    logic              accept;
    logic              in_inside;
    logic [ADDR_W-1:0] in_addr;

    assign busy   = clearing;
    assign accept = start && !clearing;

    // A column outside the grid is never written and reads as empty.
    assign in_inside = (32'(cell_x) < 32'(GRID_X)) && (32'(cell_y) < 32'(GRID_Y));
    assign in_addr   = ADDR_W'(32'(cell_y) * 32'(GRID_X) + 32'(cell_x));

    // ------------------------------------------------------------------
    // Stage 1: the column word arrives from memory. A load writes the
    // modified word back; a query builds its layer masks and counts the
    // band in groups of eight.
    // ------------------------------------------------------------------
    logic                             s1_valid_reg;
    logic                             s1_type_reg;
    logic                             s1_inside_reg;
    logic [ADDR_W-1:0]                s1_addr_reg;
    logic [vcoc_pkg::LAYER_Z_W-1:0]   s1_z_reg;
    logic                             s1_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg   <= req_type;
            s1_inside_reg <= in_inside;
            s1_addr_reg   <= in_addr;
            s1_z_reg      <= layer_z;
            s1_fill_reg   <= voxel_filled;
        end
    end

    logic [LAYERS-1:0] col_word;
    logic [LAYERS-1:0] new_word;
    logic              wr_en;

    vcoc_column_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .COL_W  (LAYERS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (in_addr),
        .rd_data  (col_word),
        .wr_en    (wr_en),
        .wr_addr  (s1_addr_reg),
        .wr_data  (new_word),
        .clearing (clearing)
    );

    // Load path: a layer beyond the column or a cell beyond the grid is ignored.
    always_comb
    begin
        for (int i = 0; i < LAYERS; i++)
        begin
            new_word[i] = (i == int'(s1_z_reg)) ? s1_fill_reg : col_word[i];
        end
    end

    assign wr_en = s1_valid_reg && (s1_type_reg == vcoc_pkg::REQ_LOAD) && s1_inside_reg
                   && (32'(s1_z_reg) < 32'(LAYERS));

    // Query path.
    logic [L_W-1:0]                 eff_layers;
    logic                           band_mode;
    logic [vcoc_pkg::FLOOR_W:0]     band_lo;
    logic [L_W-1:0]                 band_n;
    logic [NGRP*8-1:0]              band_bits;
    logic [LAYERS-1:0]              below_bits;
    logic [LAYERS-1:0]              floor_bits;
    logic [vcoc_pkg::GRP_CNT_W-1:0] grp_cnt_next [NGRP];

    always_comb
    begin
        // A layer count beyond the column width is clipped to it.
        if (32'(layer_count_reg) > 32'(LAYERS))
        begin
            eff_layers = L_W'(LAYERS);
        end
        else
        begin
            eff_layers = L_W'(layer_count_reg);
        end

        // Mode three falls back to the all-layer test.
        band_mode = (class_mode_reg == vcoc_pkg::MODE_BELOW)
                 || (class_mode_reg == vcoc_pkg::MODE_BELOW_FLOOR);
        band_lo   = band_mode ? ({1'b0, floor_index_reg} + (vcoc_pkg::FLOOR_W + 1)'(2))
                              : '0;

        if (32'(band_lo) < 32'(eff_layers))
        begin
            band_n = eff_layers - L_W'(band_lo);
        end
        else
        begin
            band_n = '0;
        end

        // Masks of the below range, the floor range and the ratio band.
        band_bits = '0;
        for (int i = 0; i < LAYERS; i++)
        begin
            logic bit_on;
            bit_on        = s1_inside_reg && col_word[i] && (i < int'(eff_layers));
            below_bits[i] = bit_on && (i + 1 < int'(floor_index_reg));
            floor_bits[i] = bit_on && (i + 1 >= int'(floor_index_reg))
                                   && (i < int'(floor_index_reg) + 2);
            band_bits[i]  = bit_on && (i >= int'(band_lo));
        end

        for (int g = 0; g < NGRP; g++)
        begin
            grp_cnt_next[g] = '0;
            for (int k = 0; k < 8; k++)
            begin
                grp_cnt_next[g] = grp_cnt_next[g]
                                + vcoc_pkg::GRP_CNT_W'(band_bits[g * 8 + k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the group counts are summed into the band count.
    // ------------------------------------------------------------------
    vcoc_pkg::stage_ctl_t           s2_ctl_reg;
    vcoc_pkg::stage_ctl_t           s2_ctl_next;
    logic [vcoc_pkg::GRP_CNT_W-1:0] s2_grp_cnt_reg [NGRP];
    logic [L_W-1:0]                 s2_n_reg;

    always_comb
    begin
        s2_ctl_next.valid      = s1_valid_reg && (s1_type_reg == vcoc_pkg::REQ_QUERY);
        s2_ctl_next.below      = band_mode && (below_bits != '0);
        s2_ctl_next.floor_seen = band_mode && (floor_bits != '0);
        s2_ctl_next.mode       = class_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_grp_cnt_reg <= grp_cnt_next;
        s2_n_reg       <= band_n;
    end

    logic [L_W-1:0] s3_c_next;

    always_comb
    begin
        s3_c_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            s3_c_next = s3_c_next + L_W'(s2_grp_cnt_reg[g]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: ratio tests and classification into the output register.
    // ------------------------------------------------------------------
    vcoc_pkg::stage_ctl_t s3_ctl_reg;
    logic [L_W-1:0]       s3_c_reg;
    logic [L_W-1:0]       s3_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else
        begin
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_c_reg <= s3_c_next;
        s3_n_reg <= s2_n_reg;
    end

    logic                          ge_hi;
    logic                          ge_band;
    logic                          le_lo;
    logic [vcoc_pkg::CLASS_W-1:0]  cell_class_next;
    logic [vcoc_pkg::COUNT_W-1:0]  band_count_next;

    always_comb
    begin
        // An empty band fails all three ratio tests.
        ge_hi   = (s3_n_reg != '0)
               && (32'(s3_c_reg) * 32'(vcoc_pkg::RATIO_HI_MUL) >= 32'(s3_n_reg));
        ge_band = (s3_n_reg != '0)
               && (32'(s3_c_reg) * 32'(vcoc_pkg::RATIO_BAND_MUL) >= 32'(s3_n_reg));
        le_lo   = (s3_n_reg != '0)
               && (32'(s3_c_reg) * 32'(vcoc_pkg::RATIO_LO_CMUL)
                   <= 32'(s3_n_reg) * 32'(vcoc_pkg::RATIO_LO_NMUL));

        case (s3_ctl_reg.mode)
            vcoc_pkg::MODE_BELOW:
            begin
                if (ge_band || s3_ctl_reg.below)
                begin
                    cell_class_next = vcoc_pkg::CLASS_OCCUPIED;
                end
                else if (le_lo)
                begin
                    cell_class_next = vcoc_pkg::CLASS_FREE;
                end
                else
                begin
                    cell_class_next = vcoc_pkg::CLASS_UNKNOWN;
                end
            end
            vcoc_pkg::MODE_BELOW_FLOOR:
            begin
                if (ge_hi || s3_ctl_reg.below)
                begin
                    cell_class_next = vcoc_pkg::CLASS_OCCUPIED;
                end
                else if (le_lo && s3_ctl_reg.floor_seen)
                begin
                    cell_class_next = vcoc_pkg::CLASS_FREE;
                end
                else
                begin
                    cell_class_next = vcoc_pkg::CLASS_UNKNOWN;
                end
            end
            default:
            begin
                if (ge_hi)
                begin
                    cell_class_next = vcoc_pkg::CLASS_OCCUPIED;
                end
                else if (le_lo)
                begin
                    cell_class_next = vcoc_pkg::CLASS_FREE;
                end
                else
                begin
                    cell_class_next = vcoc_pkg::CLASS_UNKNOWN;
                end
            end
        endcase

        // The reported count saturates at the port's maximum.
        if (32'(s3_c_reg) > 32'(vcoc_pkg::COUNT_MAX))
        begin
            band_count_next = vcoc_pkg::COUNT_W'(vcoc_pkg::COUNT_MAX);
        end
        else
        begin
            band_count_next = vcoc_pkg::COUNT_W'(s3_c_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register: one result transfer per query.
    // ------------------------------------------------------------------
    logic                         done_reg;
    logic [vcoc_pkg::CLASS_W-1:0] cell_class_reg;
    logic [vcoc_pkg::COUNT_W-1:0] band_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_class_reg <= cell_class_next;
        band_count_reg <= band_count_next;
    end

    assign done       = done_reg;
    assign cell_class = cell_class_reg;
    assign band_count = band_count_reg;

endmodule

`default_nettype wire

[rtl/core/vcoc_checker.sv]
// ============================================================================
// vcoc_checker
// Port-level checks of the voxel column occupancy classifier.
// ============================================================================
`default_nettype none

module vcoc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             req_type,
    input wire logic                             done,
    input wire logic [vcoc_pkg::CLASS_W-1:0]     cell_class,
    input wire logic [vcoc_pkg::COUNT_W-1:0]     band_count
);

    // Once the clearing sweep has finished, the block never goes busy again.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
    else $error("busy rose after the clearing sweep had finished");

    // Every query transfer is followed by a result on done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == vcoc_pkg::REQ_QUERY)) |-> ##4 done)
    else $error("query transfer produced no result");

    // No result appears without a matching earlier query transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (req_type == vcoc_pkg::REQ_QUERY), 4))
    else $error("result without a matching query transfer");

    // A free column holds at most a 0.036 share of its band, so at most one voxel of 32; checked as at most two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (cell_class == vcoc_pkg::CLASS_FREE)) |-> (band_count <= 6'd2))
    else $error("free column reported with too many filled voxels");

endmodule

bind voxel_column_occupancy_classifier vcoc_checker u_vcoc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .done       (done),
    .cell_class (cell_class),
    .band_count (band_count)
);

`default_nettype wire
